FILE: hw/rtl/lbac_pkg.sv
// ----------------------------------------------------------------------------
// lbac_pkg
// Shared types, constants and helpers for the light beam alarm controller.
// ----------------------------------------------------------------------------
package lbac_pkg;

  localparam int unsigned COUNT_BITS  = 16;
  localparam int unsigned SAMPLE_BITS = 10;
  localparam int unsigned CFG_BITS    = 16;
  localparam int unsigned CFG_IDX_BITS = 2;
  localparam int unsigned NUM_BUTTONS = 3;

  typedef logic [COUNT_BITS-1:0]  count_t;
  typedef logic [SAMPLE_BITS-1:0] sample_t;

  localparam count_t  CNT_MAX = {COUNT_BITS{1'b1}};

  // Register reset values
  localparam sample_t TRIP_THRESHOLD_RST = SAMPLE_BITS'(600);
  localparam count_t  BLINK_TICKS_RST    = COUNT_BITS'(150);
  localparam count_t  DEBOUNCE_TICKS_RST = COUNT_BITS'(50);

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_TRIP_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_BLINK_TICKS    = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DEBOUNCE_TICKS = 2'd2;

  // Button slots
  localparam int unsigned BTN_POWER  = 0;
  localparam int unsigned BTN_RESET  = 1;
  localparam int unsigned BTN_SILENT = 2;

  // Held output levels
  typedef struct packed {
    logic alarm;
    logic armed;
    logic silent;
    logic status;
    logic light;
    logic buzz;
  } levels_t;

  localparam levels_t BOOT_LEVELS = '{alarm: 1'b0, armed: 1'b1, silent: 1'b0,
                                      status: 1'b0, light: 1'b1, buzz: 1'b0};
  localparam levels_t OFF_LEVELS  = '{alarm: 1'b0, armed: 1'b0, silent: 1'b0,
                                      status: 1'b1, light: 1'b0, buzz: 1'b0};

  // Debouncer state of one button
  typedef struct packed {
    logic   last;
    logic   stable;
    count_t quiet;
  } btn_t;

  typedef struct packed {
    logic press;
    btn_t btn;
  } btn_step_t;

  function automatic count_t sat_inc(input count_t v);
    return (v == CNT_MAX) ? v : v + count_t'(1);
  endfunction

  // One debounce step; press flags an accepted 1 -> 0 transition.
  function automatic btn_step_t debounce(input btn_t cur, input logic level,
                                         input count_t deb);
    btn_step_t r;
    count_t    q;
    r.press = 1'b0;
    r.btn   = cur;
    q       = (level != cur.last) ? '0 : cur.quiet;
    if (q > deb) begin
      r.press      = !level && cur.stable;
      r.btn.stable = level;
    end
    r.btn.last  = level;
    r.btn.quiet = sat_inc(q);
    return r;
  endfunction

endpackage

FILE: hw/rtl/light_beam_alarm_controller_unit.sv
// ----------------------------------------------------------------------------
// light_beam_alarm_controller_unit
// Beam-break alarm: button debounce, power toggle, alarm latch and blinker.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one millisecond tick: a
//   light sample, three active-low raw button levels and a remote-code flag.
//   Output channel (out_valid_o/out_ready_i) returns one transaction per tick
//   with the held LED, light source and buzzer levels plus the latch and
//   power state after that tick.
//   Each tick's result is registered and shown in the cycle after intake.
//   It takes one tick per cycle unless the receiver stalls; all state updates
//   are one pass of compares and counter steps into state/result registers.
//   in_ready_o stays high while the result register is empty or being taken,
//   so a stalled receiver holds the current result and stops intake only
//   after one pending transaction.
//   Reset leaves the unit powered, armed LED and light source on, alarm
//   clear, silent mode off, buttons seen as released, thresholds at their
//   defaults. Config writes (cfg_we_i) take effect at once; write only while
//   idle.
// ----------------------------------------------------------------------------
module light_beam_alarm_controller_unit
  import lbac_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [SAMPLE_BITS-1:0]  light_level_i,
  input  logic                    power_level_i,
  input  logic                    reset_level_i,
  input  logic                    silent_level_i,
  input  logic                    remote_code_seen_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    alarm_led_o,
  output logic                    armed_led_o,
  output logic                    silent_led_o,
  output logic                    status_led_o,
  output logic                    light_source_o,
  output logic                    buzzer_on_o,
  output logic                    is_tripped_o,
  output logic                    is_powered_o,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [CFG_BITS-1:0]     cfg_data_i
);

  sample_t threshold_q;
  count_t  blink_ticks_q;
  count_t  debounce_q;

  logic    out_valid_q;
  logic    powered_q, powered_d;
  logic    tripped_q, tripped_d;
  logic    phase_q, phase_d;
  logic    silent_q, silent_d;
  count_t  blink_cnt_q, blink_cnt_d;
  btn_t    btn_q [NUM_BUTTONS];
  btn_t    btn_d [NUM_BUTTONS];
  levels_t lvl_q, lvl_d;
  logic    accept;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    btn_step_t st;
    st          = '0;
    powered_d   = powered_q;
    tripped_d   = tripped_q;
    phase_d     = phase_q;
    silent_d    = silent_q;
    blink_cnt_d = blink_cnt_q;
    lvl_d       = lvl_q;
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      btn_d[b] = btn_q[b];
    end

    // Remote code toggles power
    if (remote_code_seen_i) begin
      if (powered_d) begin
        powered_d = 1'b0;
        tripped_d = 1'b0;
        phase_d   = 1'b0;
        lvl_d     = OFF_LEVELS;
      end else begin
        powered_d = 1'b1;
        silent_d  = !silent_level_i;
        lvl_d     = BOOT_LEVELS;
      end
    end

    st               = debounce(btn_q[BTN_POWER], power_level_i, debounce_q);
    btn_d[BTN_POWER] = st.btn;
    if (st.press) begin
      if (powered_d) begin
        powered_d = 1'b0;
        tripped_d = 1'b0;
        phase_d   = 1'b0;
        lvl_d     = OFF_LEVELS;
      end else begin
        powered_d = 1'b1;
        silent_d  = !silent_level_i;
        lvl_d     = BOOT_LEVELS;
      end
    end

    if (!powered_d) begin
      // buttons not sampled while off, but quiet time still runs
      btn_d[BTN_RESET].quiet  = sat_inc(btn_q[BTN_RESET].quiet);
      btn_d[BTN_SILENT].quiet = sat_inc(btn_q[BTN_SILENT].quiet);
    end else begin
      if ((light_level_i < threshold_q) && !tripped_d) begin
        tripped_d   = 1'b1;
        blink_cnt_d = '0;
      end
      if (tripped_d) begin
        if (blink_cnt_d >= blink_ticks_q) begin
          blink_cnt_d = '0;
          phase_d     = !phase_d;
          lvl_d.alarm = phase_d;
          lvl_d.light = 1'b0;
          lvl_d.armed = 1'b0;
          lvl_d.buzz  = phase_d && !silent_d;
        end
        blink_cnt_d = sat_inc(blink_cnt_d);
      end else begin
        lvl_d.alarm = 1'b0;
        lvl_d.armed = 1'b1;
        lvl_d.buzz  = 1'b0;
      end

      st               = debounce(btn_q[BTN_RESET], reset_level_i, debounce_q);
      btn_d[BTN_RESET] = st.btn;
      if (st.press && tripped_d) begin
        tripped_d = 1'b0;
        phase_d   = 1'b0;
        lvl_d     = BOOT_LEVELS;
      end

      st                = debounce(btn_q[BTN_SILENT], silent_level_i, debounce_q);
      btn_d[BTN_SILENT] = st.btn;
      if (st.press) begin
        silent_d     = !silent_d;
        lvl_d.silent = silent_d;
        if (tripped_d && silent_d) begin
          lvl_d.buzz = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q   <= TRIP_THRESHOLD_RST;
      blink_ticks_q <= BLINK_TICKS_RST;
      debounce_q    <= DEBOUNCE_TICKS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_TRIP_THRESHOLD: threshold_q   <= cfg_data_i[SAMPLE_BITS-1:0];
        CFG_BLINK_TICKS:    blink_ticks_q <= cfg_data_i[COUNT_BITS-1:0];
        CFG_DEBOUNCE_TICKS: debounce_q    <= cfg_data_i[COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      powered_q   <= 1'b1;
      tripped_q   <= 1'b0;
      phase_q     <= 1'b0;
      silent_q    <= 1'b0;
      blink_cnt_q <= '0;
      lvl_q       <= BOOT_LEVELS;
      for (int b = 0; b < NUM_BUTTONS; b++) begin
        btn_q[b] <= '{last: 1'b1, stable: 1'b1, quiet: '0};
      end
    end else begin
      if (accept) begin
        out_valid_q <= 1'b1;
        powered_q   <= powered_d;
        tripped_q   <= tripped_d;
        phase_q     <= phase_d;
        silent_q    <= silent_d;
        blink_cnt_q <= blink_cnt_d;
        lvl_q       <= lvl_d;
        for (int b = 0; b < NUM_BUTTONS; b++) begin
          btn_q[b] <= btn_d[b];
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // State registers double as the result register: they only move on intake.
  assign out_valid_o    = out_valid_q;
  assign alarm_led_o    = lvl_q.alarm;
  assign armed_led_o    = lvl_q.armed;
  assign silent_led_o   = lvl_q.silent;
  assign status_led_o   = lvl_q.status;
  assign light_source_o = lvl_q.light;
  assign buzzer_on_o    = lvl_q.buzz;
  assign is_tripped_o   = tripped_q;
  assign is_powered_o   = powered_q;

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for light_beam_alarm_controller_unit. Millisecond ticks go in over
// a valid/ready channel with bursty gaps. Each tick also runs through an alarm
// model kept in this file. Every result transaction, taken under a receiver
// with changing stall patterns, is compared field by field with the oldest
// pending prediction.
// ----------------------------------------------------------------------------
module tb;
  import lbac_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned SAMPLE_TOP  = (1 << SAMPLE_BITS) - 1;

  typedef struct packed {
    levels_t lv;
    logic    tripped;
    logic    powered;
  } tick_result_t;

  typedef enum logic [1:0] {RX_STREAM, RX_MOSTLY, RX_SPARSE, RX_PERIODIC} rx_mode_e;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic [SAMPLE_BITS-1:0]  light_level_i = '0;
  logic                    power_level_i = 1'b1;
  logic                    reset_level_i = 1'b1;
  logic                    silent_level_i = 1'b1;
  logic                    remote_code_seen_i = 1'b0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic                    alarm_led_o;
  logic                    armed_led_o;
  logic                    silent_led_o;
  logic                    status_led_o;
  logic                    light_source_o;
  logic                    buzzer_on_o;
  logic                    is_tripped_o;
  logic                    is_powered_o;
  logic                    cfg_we_i = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index_i = '0;
  logic [CFG_BITS-1:0]     cfg_data_i = '0;

  light_beam_alarm_controller_unit dut (.*);

  always #5 clk_i = ~clk_i;

  // Alarm model state and its copy of the registers
  sample_t threshold_cfg;
  count_t  blink_cfg;
  count_t  debounce_cfg;
  logic    pwr_on;
  logic    latched;
  logic    blink_on;
  logic    silent_on;
  count_t  blink_ctr;
  logic    btn_last   [NUM_BUTTONS];
  logic    btn_stable [NUM_BUTTONS];
  count_t  btn_quiet  [NUM_BUTTONS];
  levels_t held;

  tick_result_t expected_ticks[$];
  tick_result_t due;
  int unsigned  fail_count = 0;
  int unsigned  burst_left = 0;
  int unsigned  idle_cycles = 0;
  int unsigned  rx_left = 0;
  rx_mode_e     rx_mode = RX_STREAM;

  function automatic count_t ctr_step(input count_t v);
    return (v == '1) ? v : v + count_t'(1);
  endfunction

  // Returns 1 on an accepted press: stable level goes from released to pressed.
  function automatic logic debounce_press(input int unsigned b, input logic level);
    logic hit;
    hit = 1'b0;
    if (level != btn_last[b]) btn_quiet[b] = '0;
    if (btn_quiet[b] > debounce_cfg) begin
      hit = !level && btn_stable[b];
      btn_stable[b] = level;
    end
    btn_last[b]  = level;
    btn_quiet[b] = ctr_step(btn_quiet[b]);
    return hit;
  endfunction

  function automatic void toggle_power(input logic sil);
    if (pwr_on) begin
      held     = OFF_LEVELS;
      latched  = 1'b0;
      blink_on = 1'b0;
      pwr_on   = 1'b0;
    end else begin
      pwr_on    = 1'b1;
      silent_on = !sil;
      held      = BOOT_LEVELS;
    end
  endfunction

  function automatic void reset_alarm_model();
    threshold_cfg = TRIP_THRESHOLD_RST;
    blink_cfg     = BLINK_TICKS_RST;
    debounce_cfg  = DEBOUNCE_TICKS_RST;
    pwr_on        = 1'b1;
    latched       = 1'b0;
    blink_on      = 1'b0;
    silent_on     = 1'b0;
    blink_ctr     = '0;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      btn_last[i]   = 1'b1;
      btn_stable[i] = 1'b1;
      btn_quiet[i]  = '0;
    end
    held = BOOT_LEVELS;
  endfunction

  function automatic void advance_alarm_model(input sample_t light, input logic pwr,
                                              input logic rst, input logic sil,
                                              input logic remote);
    tick_result_t r;
    if (remote) toggle_power(sil);
    if (debounce_press(BTN_POWER, pwr)) toggle_power(sil);
    if (!pwr_on) begin
      // buttons unsampled while off, but their quiet time still runs
      btn_quiet[BTN_RESET]  = ctr_step(btn_quiet[BTN_RESET]);
      btn_quiet[BTN_SILENT] = ctr_step(btn_quiet[BTN_SILENT]);
    end else begin
      if (light < threshold_cfg && !latched) begin
        latched   = 1'b1;
        blink_ctr = '0;
      end
      if (latched) begin
        if (blink_ctr >= blink_cfg) begin
          blink_ctr  = '0;
          blink_on   = !blink_on;
          held.alarm = blink_on;
          held.light = 1'b0;
          held.armed = 1'b0;
          held.buzz  = blink_on && !silent_on;
        end
        blink_ctr = ctr_step(blink_ctr);
      end else begin
        held.alarm = 1'b0;
        held.armed = 1'b1;
        held.buzz  = 1'b0;
      end
      if (debounce_press(BTN_RESET, rst) && latched) begin
        latched  = 1'b0;
        blink_on = 1'b0;
        held     = BOOT_LEVELS;
      end
      if (debounce_press(BTN_SILENT, sil)) begin
        silent_on   = !silent_on;
        held.silent = silent_on;
        if (latched && silent_on) held.buzz = 1'b0;
      end
    end
    r.lv      = held;
    r.tripped = latched;
    r.powered = pwr_on;
    expected_ticks.push_back(r);
  endfunction

  function automatic void check_field(input string name, input logic want, input logic got);
    if (want !== got) begin
      $error("%s: expected %0b, got %0b", name, want, got);
      fail_count++;
    end
  endfunction

  // Sends one tick transaction; the model advances when it is taken.
  task automatic send_tick(input sample_t light, input logic pwr, input logic rst,
                           input logic sil, input logic remote);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    @(negedge clk_i);
    in_valid_i         <= 1'b1;
    light_level_i      <= light;
    power_level_i      <= pwr;
    reset_level_i      <= rst;
    silent_level_i     <= sil;
    remote_code_seen_i <= remote;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    advance_alarm_model(light, pwr, rst, sil, remote);
    burst_left--;
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (expected_ticks.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_config(input sample_t thr, input count_t blink, input count_t deb);
    drain_results();
    write_reg(CFG_TRIP_THRESHOLD, CFG_BITS'(thr));
    write_reg(CFG_BLINK_TICKS, blink);
    write_reg(CFG_DEBOUNCE_TICKS, deb);
    threshold_cfg = thr;
    blink_cfg     = blink;
    debounce_cfg  = deb;
  endtask

  function automatic sample_t clear_sample();
    return sample_t'($urandom_range(threshold_cfg, SAMPLE_TOP));
  endfunction

  function automatic sample_t break_sample();
    return (threshold_cfg == 0) ? '0 : sample_t'($urandom_range(0, threshold_cfg - 1));
  endfunction

  function automatic sample_t any_sample();
    return ($urandom_range(0, 5) == 0) ? break_sample() : clear_sample();
  endfunction

  // Edge of the threshold range, blink interval of zero toggles every tick
  task automatic test_trip_and_blink();
    set_config(sample_t'(SAMPLE_TOP), '0, '0);
    send_tick(sample_t'(SAMPLE_TOP), 1'b1, 1'b1, 1'b1, 1'b0);
    send_tick('0, 1'b1, 1'b1, 1'b1, 1'b0);
    send_tick(sample_t'(512), 1'b1, 1'b1, 1'b1, 1'b0);
    send_tick(sample_t'(SAMPLE_TOP), 1'b1, 1'b1, 1'b1, 1'b0);
  endtask

  task automatic test_buttons_and_power();
    // silent press while tripped mutes the buzzer, then release
    repeat (2) send_tick(sample_t'(SAMPLE_TOP), 1'b1, 1'b1, 1'b0, 1'b0);
    repeat (2) send_tick(sample_t'(SAMPLE_TOP), 1'b1, 1'b1, 1'b1, 1'b0);
    // reset press clears the latch; a second press finds nothing to clear
    repeat (2) send_tick(sample_t'(SAMPLE_TOP), 1'b1, 1'b0, 1'b1, 1'b0);
    repeat (2) send_tick(sample_t'(SAMPLE_TOP), 1'b1, 1'b1, 1'b1, 1'b0);
    repeat (2) send_tick(sample_t'(SAMPLE_TOP), 1'b1, 1'b0, 1'b1, 1'b0);
    // power button off, samples ignored, remote on with silent held
    repeat (2) send_tick(sample_t'(SAMPLE_TOP), 1'b0, 1'b1, 1'b1, 1'b0);
    send_tick('0, 1'b1, 1'b1, 1'b0, 1'b0);
    send_tick('0, 1'b1, 1'b1, 1'b0, 1'b1);
    send_tick('0, 1'b1, 1'b1, 1'b1, 1'b1);
  endtask

  // Debounce at counter max never accepts; zero threshold never trips
  task automatic test_counter_limits();
    set_config('0, '1, '1);
    send_tick('0, 1'b1, 1'b1, 1'b1, 1'b1);
    repeat (2) send_tick('0, 1'b0, 1'b1, 1'b1, 1'b0);
    set_config(sample_t'(1), '1, '1);
    send_tick('0, 1'b0, 1'b0, 1'b0, 1'b0);
  endtask

  // Mostly clean button sequences and beam breaks, some bounces and noise
  task automatic test_random_mix(input int unsigned n_ticks);
    int unsigned sent;
    int unsigned pick;
    int unsigned len;
    logic [2:0]  btns;
    sent = 0;
    while (sent < n_ticks) begin
      pick = $urandom_range(0, 9);
      btns = 3'b111;
      case (pick)
        0, 1, 2: begin
          len = int'(debounce_cfg) + 1 + $urandom_range(0, 2);
          btns[pick] = 1'b0;
          repeat (len) send_tick(any_sample(), btns[BTN_POWER], btns[BTN_RESET],
                                 btns[BTN_SILENT], 1'b0);
          repeat (len) send_tick(any_sample(), 1'b1, 1'b1, 1'b1, 1'b0);
          sent += 2 * len;
        end
        3: begin
          send_tick(any_sample(), 1'b1, 1'b1, 1'($urandom_range(0, 1)), 1'b1);
          sent += 1;
        end
        4: begin
          len = $urandom_range(1, 6);
          repeat (len) send_tick(break_sample(), 1'b1, 1'b1, 1'b1, 1'b0);
          sent += len;
        end
        5, 6: begin
          len = $urandom_range(1, 12);
          repeat (len) send_tick(clear_sample(), 1'b1, 1'b1, 1'b1, 1'b0);
          sent += len;
        end
        7: begin
          // bounce shorter than the debounce window
          len = (debounce_cfg == 0) ? 1 : $urandom_range(1, debounce_cfg);
          btns[$urandom_range(0, 2)] = 1'b0;
          repeat (len) send_tick(any_sample(), btns[BTN_POWER], btns[BTN_RESET],
                                 btns[BTN_SILENT], 1'b0);
          send_tick(any_sample(), 1'b1, 1'b1, 1'b1, 1'b0);
          sent += len + 1;
        end
        default: begin
          len = $urandom_range(1, 4);
          repeat (len) send_tick(sample_t'($urandom_range(0, SAMPLE_TOP)),
                                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                 1'($urandom_range(0, 1)), ($urandom_range(0, 7) == 0));
          sent += len;
        end
      endcase
    end
  endtask

  // Receiver: stall pattern changes every so often
  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(20, 200);
    end
    rx_left--;
    case (rx_mode)
      RX_STREAM:   out_ready_i <= 1'b1;
      RX_MOSTLY:   out_ready_i <= ($urandom_range(0, 3) != 0);
      RX_SPARSE:   out_ready_i <= ($urandom_range(0, 3) == 0);
      default:     out_ready_i <= (rx_left % 3 != 0);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_ticks.size() == 0) begin
        $error("result transaction with no tick pending");
        fail_count++;
      end else begin
        due = expected_ticks.pop_front();
        check_field("alarm_led", due.lv.alarm, alarm_led_o);
        check_field("armed_led", due.lv.armed, armed_led_o);
        check_field("silent_led", due.lv.silent, silent_led_o);
        check_field("status_led", due.lv.status, status_led_o);
        check_field("light_source", due.lv.light, light_source_o);
        check_field("buzzer_on", due.lv.buzz, buzzer_on_o);
        check_field("is_tripped", due.tripped, is_tripped_o);
        check_field("is_powered", due.powered, is_powered_o);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    reset_alarm_model();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_trip_and_blink();
    test_buttons_and_power();
    test_counter_limits();

    set_config(sample_t'(600), count_t'(3), count_t'(2));
    test_random_mix(500);
    set_config(sample_t'(SAMPLE_TOP), count_t'(1), '0);
    test_random_mix(300);
    set_config(sample_t'(1), count_t'(20), count_t'(7));
    test_random_mix(300);
    set_config(TRIP_THRESHOLD_RST, BLINK_TICKS_RST, DEBOUNCE_TICKS_RST);
    test_random_mix(400);

    drain_results();
    repeat (5) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
